FILE: rtl/block_table_first_fit_allocator_defines.svh
// Assertion macros used by the block table allocator checker.
`ifndef BLOCK_TABLE_FIRST_FIT_ALLOCATOR_DEFINES_SVH
`define BLOCK_TABLE_FIRST_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define BTFFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define BTFFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/btffa_pkg.sv
// Types and constants of the block table first-fit allocator.
`default_nettype none

package btffa_pkg;

    // Width of the block count register and of the changed-entry count.
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = 11'd1024;

    // Table entry marks.
    localparam logic [2:0] ENT_FREE  = 3'b000;
    localparam logic [2:0] ENT_TAKEN = 3'b001;
    localparam logic [2:0] ENT_FIRST = 3'b010;
    localparam logic [2:0] ENT_NEXT  = 3'b100;

    // Request kinds.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_OUTSIDE = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_PRIME,
        S_SCAN,
        S_MARK,
        S_WALK
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic pos_zero;
        logic pos_blk;
        logic pos_start;
        logic pos_inc;
        logic rd_ahead;
        logic wr_zero;
        logic wr_mark;
        logic scan_eval;
        logic cnt_clr;
        logic cnt_inc;
        logic res_ok_alloc;
        logic res_ok_free;
        logic res_no_fit;
        logic res_outside;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_free;
        logic size_zero;
        logic too_big;
        logic outside;
        logic has_next;
        logic found;
        logic at_end;
        logic at_last;
        logic clr_end;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/btffa_ctrl.sv
// Controller state machine of the block table allocator.
`default_nettype none

module btffa_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire btffa_pkg::dp_stat_t stat,
    output btffa_pkg::dp_cmd_t       cmd,
    output logic                     busy
);

    btffa_pkg::state_t state_reg;
    btffa_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btffa_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != btffa_pkg::S_IDLE);
        unique case (state_reg)
            btffa_pkg::S_CLEAR:
            begin
                cmd.wr_zero = 1'b1;
                cmd.pos_inc = 1'b1;
                if (stat.clr_end)
                begin
                    state_next = btffa_pkg::S_IDLE;
                end
            end
            btffa_pkg::S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = btffa_pkg::S_CHECK;
                end
            end
            btffa_pkg::S_CHECK:
            begin
                cmd.cnt_clr = 1'b1;
                if (stat.op_free)
                begin
                    if (stat.outside)
                    begin
                        cmd.res_outside = 1'b1;
                        state_next      = btffa_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.pos_blk = 1'b1;
                        state_next  = btffa_pkg::S_PRIME;
                    end
                end
                else if (stat.size_zero || stat.too_big)
                begin
                    cmd.res_no_fit = 1'b1;
                    state_next     = btffa_pkg::S_IDLE;
                end
                else
                begin
                    cmd.pos_zero = 1'b1;
                    state_next   = btffa_pkg::S_PRIME;
                end
            end
            btffa_pkg::S_PRIME:
            begin
                state_next = stat.op_free ? btffa_pkg::S_WALK : btffa_pkg::S_SCAN;
            end
            btffa_pkg::S_SCAN:
            begin
                cmd.scan_eval = 1'b1;
                cmd.rd_ahead  = 1'b1;
                if (stat.found)
                begin
                    cmd.pos_start = 1'b1;
                    state_next    = btffa_pkg::S_MARK;
                end
                else if (stat.at_end)
                begin
                    cmd.res_no_fit = 1'b1;
                    state_next     = btffa_pkg::S_IDLE;
                end
                else
                begin
                    cmd.pos_inc = 1'b1;
                end
            end
            btffa_pkg::S_MARK:
            begin
                cmd.wr_mark = 1'b1;
                cmd.cnt_inc = 1'b1;
                if (stat.at_last)
                begin
                    cmd.res_ok_alloc = 1'b1;
                    state_next       = btffa_pkg::S_IDLE;
                end
                else
                begin
                    cmd.pos_inc = 1'b1;
                end
            end
            btffa_pkg::S_WALK:
            begin
                cmd.wr_zero  = 1'b1;
                cmd.cnt_inc  = 1'b1;
                cmd.rd_ahead = 1'b1;
                if (!stat.has_next || stat.at_end)
                begin
                    cmd.res_ok_free = 1'b1;
                    state_next      = btffa_pkg::S_IDLE;
                end
                else
                begin
                    cmd.pos_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = btffa_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/btffa_dp.sv
// Datapath of the block table allocator: registers, block table and result words.
`default_nettype none

module btffa_dp #(
    parameter int TABLE_BLOCKS = 1024,
    parameter int BLOCK_BYTES  = 4096
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [btffa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [31:0]                           cfg_data,
    input  wire logic                                  opcode,
    input  wire logic [31:0]                           size_bytes,
    input  wire logic [31:0]                           address,
    input  wire btffa_pkg::dp_cmd_t                    cmd,
    output btffa_pkg::dp_stat_t                        stat,
    output logic                                       done,
    output logic [1:0]                                 status,
    output logic [31:0]                                alloc_address,
    output logic [btffa_pkg::CNT_W-1:0]                blocks_changed
);

    localparam int IDX_W   = (TABLE_BLOCKS > 1) ? $clog2(TABLE_BLOCKS) : 1;
    localparam int POS_W   = ((IDX_W > btffa_pkg::CNT_W) ? IDX_W : btffa_pkg::CNT_W) + 1;
    localparam int SHIFT_W = $clog2(BLOCK_BYTES);
    localparam int CW      = btffa_pkg::CNT_W;

    logic [31:0]        heap_base_reg;
    logic [CW-1:0]      block_count_reg;
    logic               opcode_reg;
    logic [31:0]        size_reg;
    logic [31:0]        addr_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   run_reg;
    logic [POS_W-1:0]   start_reg;
    logic [POS_W-1:0]   last_reg;
    logic [CW-1:0]      chg_reg;
    logic [CW-1:0]      chg_next;
    logic [2:0]         rd_data_reg;
    logic               done_reg;
    btffa_pkg::status_t status_reg;
    logic [31:0]        addr_out_reg;
    logic [CW-1:0]      blocks_reg;

    logic [2:0]         mem [TABLE_BLOCKS];

    logic [POS_W-1:0]   count_ext;
    logic [POS_W-1:0]   n_use;
    logic [32:0]        need;
    logic [32:0]        blk;
    logic [POS_W-1:0]   eff_start;
    logic [POS_W-1:0]   rd_pos;
    logic               mem_we;
    logic [2:0]         wr_data;
    logic               taken;

    // Blocks in use: a count above the table size acts as the table size.
    assign count_ext = POS_W'(block_count_reg);
    assign n_use     = (count_ext > POS_W'(TABLE_BLOCKS)) ? POS_W'(TABLE_BLOCKS) : count_ext;

    assign need = ({1'b0, size_reg} + 33'(BLOCK_BYTES - 1)) >> SHIFT_W;
    assign blk  = ({1'b0, addr_reg} - {1'b0, heap_base_reg}) >> SHIFT_W;

    assign taken     = rd_data_reg[0];
    assign eff_start = (run_reg == '0) ? pos_reg : start_reg;
    assign rd_pos    = cmd.rd_ahead ? (pos_reg + POS_W'(1)) : pos_reg;
    assign chg_next  = chg_reg + CW'(1);

    assign stat.op_free   = (opcode_reg == btffa_pkg::OP_FREE);
    assign stat.size_zero = (size_reg == '0);
    assign stat.too_big   = (need > 33'(n_use));
    assign stat.outside   = (addr_reg < heap_base_reg) || (blk >= 33'(n_use));
    assign stat.has_next  = rd_data_reg[2];
    assign stat.found     = !taken && (need == (33'(run_reg) + 33'd1));
    assign stat.at_end    = (pos_reg == (n_use - POS_W'(1)));
    assign stat.at_last   = (pos_reg == last_reg);
    assign stat.clr_end   = (pos_reg == POS_W'(TABLE_BLOCKS - 1));

    assign mem_we = cmd.wr_zero || cmd.wr_mark;

    always_comb
    begin
        wr_data = btffa_pkg::ENT_FREE;
        if (cmd.wr_mark)
        begin
            wr_data = btffa_pkg::ENT_TAKEN;
            if (pos_reg == start_reg)
            begin
                wr_data = wr_data | btffa_pkg::ENT_FIRST;
            end
            if (pos_reg != last_reg)
            begin
                wr_data = wr_data | btffa_pkg::ENT_NEXT;
            end
        end
    end

    // Block table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[pos_reg[IDX_W-1:0]] <= wr_data;
        end
        rd_data_reg <= mem[rd_pos[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_base_reg   <= '0;
            block_count_reg <= btffa_pkg::BLOCK_COUNT_RESET;
            pos_reg         <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    btffa_pkg::CFG_HEAP_BASE:   heap_base_reg   <= cfg_data;
                    btffa_pkg::CFG_BLOCK_COUNT: block_count_reg <= cfg_data[CW-1:0];
                endcase
            end
            if (cmd.pos_zero)
            begin
                pos_reg <= '0;
            end
            else if (cmd.pos_blk)
            begin
                pos_reg <= blk[POS_W-1:0];
            end
            else if (cmd.pos_start)
            begin
                pos_reg <= eff_start;
            end
            else if (cmd.pos_inc)
            begin
                pos_reg <= pos_reg + POS_W'(1);
            end
            done_reg <= cmd.res_ok_alloc || cmd.res_ok_free || cmd.res_no_fit
                        || cmd.res_outside;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            opcode_reg <= opcode;
            size_reg   <= size_bytes;
            addr_reg   <= address;
        end
        if (cmd.cnt_clr)
        begin
            run_reg <= '0;
            chg_reg <= '0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                chg_reg <= chg_next;
            end
            if (cmd.scan_eval)
            begin
                if (taken)
                begin
                    run_reg <= '0;
                end
                else
                begin
                    run_reg   <= run_reg + POS_W'(1);
                    start_reg <= eff_start;
                    last_reg  <= pos_reg;
                end
            end
        end
        if (cmd.res_ok_alloc)
        begin
            status_reg   <= btffa_pkg::ST_OK;
            addr_out_reg <= heap_base_reg + (32'(start_reg) << SHIFT_W);
            blocks_reg   <= chg_next;
        end
        else if (cmd.res_ok_free)
        begin
            status_reg   <= btffa_pkg::ST_OK;
            addr_out_reg <= '0;
            blocks_reg   <= chg_next;
        end
        else if (cmd.res_no_fit || cmd.res_outside)
        begin
            status_reg   <= cmd.res_no_fit ? btffa_pkg::ST_NO_FIT : btffa_pkg::ST_OUTSIDE;
            addr_out_reg <= '0;
            blocks_reg   <= '0;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign alloc_address  = addr_out_reg;
    assign blocks_changed = blocks_reg;

endmodule

`default_nettype wire

FILE: rtl/block_table_first_fit_allocator.sv
// Top level of the block table first-fit heap allocator.
//
//  channel   direction  handshake                 payload
//  request   in         start, busy               opcode, size_bytes, address
//  result    out        done (one-cycle strobe)   status, alloc_address, blocks_changed
//  config    in         cfg_we                    cfg_index, cfg_data
//
// A request word is taken at a rising edge with start high and busy low; one request is
// worked at a time. An allocate scans the table up to the end of the first fitting run and
// then marks its blocks; a free clears the entries of its chain; a request refused by the size
// or range check ends after the check. The table is scanned, marked or cleared one entry per
// cycle. The result word is on done in the cycle after the last step; the receiver cannot
// stall it. After reset busy stays high while the block table is swept clear.
`default_nettype none

module block_table_first_fit_allocator #(
    parameter int TABLE_BLOCKS = 1024,
    parameter int BLOCK_BYTES  = 4096
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [btffa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                     cfg_data,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            opcode,
    input  wire logic [31:0]                     size_bytes,
    input  wire logic [31:0]                     address,
    output logic                                 done,
    output logic [1:0]                           status,
    output logic [31:0]                          alloc_address,
    output logic [btffa_pkg::CNT_W-1:0]          blocks_changed
);

    // The controller sequences the clear sweep, the size and range checks,
    // the first-fit scan, the marking of a run and the walk of a free.
    btffa_pkg::dp_cmd_t  cmd;
    btffa_pkg::dp_stat_t stat;

    btffa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath holds the configuration, the request word, the table and
    // the scan pointers, and forms the result word.
    btffa_dp #(
        .TABLE_BLOCKS (TABLE_BLOCKS),
        .BLOCK_BYTES  (BLOCK_BYTES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .opcode         (opcode),
        .size_bytes     (size_bytes),
        .address        (address),
        .cmd            (cmd),
        .stat           (stat),
        .done           (done),
        .status         (status),
        .alloc_address  (alloc_address),
        .blocks_changed (blocks_changed)
    );

endmodule

`default_nettype wire

FILE: rtl/btffa_chk.sv
// Port-level checker of the block table allocator, bound to the top level.
`default_nettype none

`include "block_table_first_fit_allocator_defines.svh"

module btffa_chk (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            start,
    input wire logic                            busy,
    input wire logic                            done,
    input wire logic [1:0]                      status,
    input wire logic [31:0]                     alloc_address,
    input wire logic [btffa_pkg::CNT_W-1:0]     blocks_changed
);

    // An accepted request keeps the block busy in the next cycle.
    `BTFFA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")

    // A result only appears once the request work is over.
    `BTFFA_ASSERT_NOW(a_done_idle, done, !busy, "result shown while busy")

    // A refused request changes nothing and returns no address.
    `BTFFA_ASSERT_NOW(a_fail_zero, done && (status != btffa_pkg::ST_OK),
        (alloc_address == '0) && (blocks_changed == '0), "refused request with payload")

    // A successful request always changes at least one entry.
    `BTFFA_ASSERT_NOW(a_ok_changed, done && (status == btffa_pkg::ST_OK),
        blocks_changed != '0, "successful request changed nothing")

endmodule

bind block_table_first_fit_allocator btffa_chk u_btffa_chk (.*);

`default_nettype wire
